// ===== sv/lrupr_pkg.sv =====
// ---------------------------------------------------------------------------
// lrupr_pkg
// shared constants, types and helpers for the lru page replacement core
// ---------------------------------------------------------------------------
package lrupr_pkg;

  localparam int FRAME_COUNT = 4;
  localparam int PAGE_BITS   = 16;
  localparam int IN_PAGE_W   = 16;
  localparam int SLOT_W      = 4;
  localparam int RANK_W      = 4;
  localparam int FAULT_W     = 32;
  localparam int FRAME_IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 56;
  localparam int OUT_USED_W  = 1 + SLOT_W + 1 + IN_PAGE_W + FAULT_W;

  typedef logic [PAGE_BITS-1:0]   page_t;
  typedef logic [FRAME_IDX_W-1:0] frame_idx_t;
  typedef logic [RANK_W-1:0]      rank_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  function automatic page_t to_page(logic [IN_PAGE_W-1:0] p);
    page_t r;
    r = '0;
    for (int i = 0; i < IN_PAGE_W; i++) begin
      if (i < PAGE_BITS) r[i] = p[i];
    end
    return r;
  endfunction

  function automatic logic [IN_PAGE_W-1:0] from_page(page_t p);
    logic [IN_PAGE_W-1:0] r;
    r = '0;
    for (int i = 0; i < PAGE_BITS; i++) begin
      if (i < IN_PAGE_W) r[i] = p[i];
    end
    return r;
  endfunction

endpackage

// ===== sv/lrupr_ctrl.sv =====
// ---------------------------------------------------------------------------
// lrupr_ctrl
// sequencer for one access at a time and the result valid flag
// ---------------------------------------------------------------------------
module lrupr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output lrupr_pkg::cmd_t   cmd
);

  lrupr_pkg::state_t state;
  lrupr_pkg::state_t state_next;
  logic              m_tvalid_next;

  always_comb begin
    state_next = state;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = lrupr_pkg::ST_EXEC;
      end
      lrupr_pkg::ST_EXEC: begin
        if (!m_tvalid || m_tready) state_next = lrupr_pkg::ST_IDLE;
      end
      default: state_next = lrupr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.capture = s_tvalid;
      end
      lrupr_pkg::ST_EXEC: begin
        cmd.execute = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.execute) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lrupr_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // a new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst) cmd.execute |-> (!m_tvalid || m_tready))
    else $error("result overwritten while stalled");

  // nothing is taken in while an access is in flight
  assert property (@(posedge clk) disable iff (rst)
    (state == lrupr_pkg::ST_EXEC) |-> !s_tready)
    else $error("input taken during execute");

  // every captured access is executed next or held
  assert property (@(posedge clk) disable iff (rst) cmd.capture |=> (state == lrupr_pkg::ST_EXEC))
    else $error("captured access lost");

endmodule

// ===== sv/lrupr_datapath.sv =====
// ---------------------------------------------------------------------------
// lrupr_datapath
// frame tags, occupancy, recency ranks, fault counter and result register
// ---------------------------------------------------------------------------
module lrupr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lrupr_pkg::cmd_t                       cmd,
  input  logic [lrupr_pkg::IN_PAGE_W-1:0]       page_number,
  output logic                                  hit,
  output logic [lrupr_pkg::SLOT_W-1:0]          frame_slot,
  output logic                                  evicted_valid,
  output logic [lrupr_pkg::IN_PAGE_W-1:0]       evicted_page,
  output logic [lrupr_pkg::FAULT_W-1:0]         fault_total
);

  lrupr_pkg::page_t      page_q;
  lrupr_pkg::page_t      resident_page [lrupr_pkg::FRAME_COUNT];
  logic [lrupr_pkg::FRAME_COUNT-1:0] occupied;
  lrupr_pkg::rank_t      rank [lrupr_pkg::FRAME_COUNT];
  lrupr_pkg::rank_t      rank_next [lrupr_pkg::FRAME_COUNT];
  logic [lrupr_pkg::FAULT_W-1:0] fault_counter;
  logic [lrupr_pkg::FAULT_W-1:0] fault_counter_next;

  logic [lrupr_pkg::FRAME_COUNT-1:0] match_vec;
  logic                  is_hit;
  logic                  any_empty;
  lrupr_pkg::frame_idx_t hit_idx;
  lrupr_pkg::frame_idx_t empty_idx;
  lrupr_pkg::frame_idx_t lru_idx;
  lrupr_pkg::frame_idx_t slot;
  lrupr_pkg::count_t     n_occ;
  lrupr_pkg::rank_t      old_rank;
  lrupr_pkg::rank_t      top_rank;
  logic                  shift_down;

  always_comb begin
    hit_idx   = '0;
    empty_idx = '0;
    lru_idx   = '0;
    n_occ     = '0;
    for (int i = lrupr_pkg::FRAME_COUNT - 1; i >= 0; i--) begin
      match_vec[i] = occupied[i] && (resident_page[i] == page_q);
      if (match_vec[i]) hit_idx = lrupr_pkg::FRAME_IDX_W'(i);
      if (!occupied[i]) empty_idx = lrupr_pkg::FRAME_IDX_W'(i);
      if (rank[i] == '0) lru_idx = lrupr_pkg::FRAME_IDX_W'(i);
      n_occ = n_occ + lrupr_pkg::count_t'(occupied[i]);
    end
    is_hit     = |match_vec;
    any_empty  = !(&occupied);
    slot       = is_hit ? hit_idx : (any_empty ? empty_idx : lru_idx);
    old_rank   = rank[slot];
    shift_down = is_hit || !any_empty;
    // fill takes the old count as its rank, hit and eviction take count minus one
    if (shift_down) begin
      top_rank = lrupr_pkg::RANK_W'(n_occ - lrupr_pkg::count_t'(1));
    end else begin
      top_rank = lrupr_pkg::RANK_W'(n_occ);
    end
    for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) begin
      rank_next[i] = rank[i];
      if (lrupr_pkg::FRAME_IDX_W'(i) == slot) begin
        rank_next[i] = top_rank;
      end else if (shift_down && occupied[i] && (rank[i] > old_rank)) begin
        rank_next[i] = rank[i] - lrupr_pkg::rank_t'(1);
      end
    end
    fault_counter_next = fault_counter;
    if (!is_hit && (fault_counter != '1)) begin
      fault_counter_next = fault_counter + lrupr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) page_q <= lrupr_pkg::to_page(page_number);
    if (cmd.execute) begin
      if (!is_hit) resident_page[slot] <= page_q;
      hit           <= is_hit;
      frame_slot    <= lrupr_pkg::SLOT_W'(slot);
      evicted_valid <= !is_hit && !any_empty;
      evicted_page  <= (!is_hit && !any_empty) ?
                       lrupr_pkg::from_page(resident_page[slot]) : '0;
      fault_total   <= fault_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied      <= '0;
      fault_counter <= '0;
      for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) rank[i] <= '0;
    end else if (cmd.execute) begin
      if (!is_hit) occupied[slot] <= 1'b1;
      fault_counter <= fault_counter_next;
      for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) rank[i] <= rank_next[i];
    end
  end

  // a page is resident in at most one frame
  assert property (@(posedge clk) disable iff (rst) $onehot0(match_vec))
    else $error("page resident in two frames");

  // frames never become empty again
  assert property (@(posedge clk) disable iff (rst) &(occupied | ~$past(occupied)))
    else $error("occupied frame dropped");

  // fault count moves by at most one per cycle
  assert property (@(posedge clk) disable iff (rst)
    (fault_counter == $past(fault_counter)) ||
    (fault_counter == $past(fault_counter) + lrupr_pkg::FAULT_W'(1)))
    else $error("fault counter jumped");

endmodule

// ===== sv/lru_page_replacement_core.sv =====
// ---------------------------------------------------------------------------
// lru_page_replacement_core
// fully associative lru page-frame tracker, one result item per access
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  page_number
//  m_*      out  m_tvalid/m_tready  hit, frame_slot, evicted_valid, evicted_page, fault_total
//
//  an item is captured in idle, then tag compare and rank update run in the execute state
//  the result register frees the input side, so the next item is taken while a result waits
//  a stalled result keeps the following item in execute, and no further item is taken
//  rst clears occupancy, ranks, fault count and the result valid flag
// ---------------------------------------------------------------------------
module lru_page_replacement_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [lrupr_pkg::IN_DATA_W-1:0]     s_tdata,   // page_number
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [lrupr_pkg::OUT_DATA_W-1:0]    m_tdata    // hit, frame_slot, evicted_valid,
                                                         // evicted_page, fault_total
);

  lrupr_pkg::cmd_t                 cmd;
  logic                            hit;
  logic [lrupr_pkg::SLOT_W-1:0]    frame_slot;
  logic                            evicted_valid;
  logic [lrupr_pkg::IN_PAGE_W-1:0] evicted_page;
  logic [lrupr_pkg::FAULT_W-1:0]   fault_total;

  lrupr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  lrupr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .page_number   (s_tdata[lrupr_pkg::IN_PAGE_W-1:0]),
    .hit           (hit),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

  assign m_tdata = {{(lrupr_pkg::OUT_DATA_W - lrupr_pkg::OUT_USED_W){1'b0}},
                    fault_total, evicted_page, evicted_valid, frame_slot, hit};

endmodule

// ===== sim/lru_page_replacement_core_test.sv =====
// ---------------------------------------------------------------------------
// lru_page_replacement_core_test
// streams page accesses through the core, predicts hit, frame, eviction and
// fault count for each one, and checks every result item against the
// prediction under random idling and backpressure on both sides
// ---------------------------------------------------------------------------
module lru_page_replacement_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lrupr_pkg::OUT_DATA_W-lrupr_pkg::OUT_USED_W-1:0] pad;
    logic [lrupr_pkg::FAULT_W-1:0]                          faults;
    logic [lrupr_pkg::IN_PAGE_W-1:0]                        ev_page;
    logic                                                   ev_valid;
    logic [lrupr_pkg::SLOT_W-1:0]                           slot;
    logic                                                   hit;
  } access_result_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [lrupr_pkg::IN_DATA_W-1:0]  s_tdata = '0;   // page_number
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [lrupr_pkg::OUT_DATA_W-1:0] m_tdata;        // hit, frame_slot, evicted_valid,
                                                    // evicted_page, fault_total

  lru_page_replacement_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted frame table
  lrupr_pkg::page_t frame_page [lrupr_pkg::FRAME_COUNT];
  bit               frame_full [lrupr_pkg::FRAME_COUNT];
  lrupr_pkg::rank_t frame_age_rank [lrupr_pkg::FRAME_COUNT];
  logic [31:0]      fault_tally;

  logic [lrupr_pkg::IN_DATA_W-1:0] page_queue [$];
  access_result_t                  expected_results [$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  holds_asked = 0;
  int  holds_done = 0;
  int  hold_left = 0;
  bit  page_taken = 1'b0;
  int  error_count = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  fills_seen = 0;
  int  evictions_seen = 0;

  function automatic int frames_in_use();
    int n;
    n = 0;
    for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) if (frame_full[i]) n++;
    return n;
  endfunction

  function automatic void make_most_recent(int f);
    lrupr_pkg::rank_t old_rank;
    old_rank = frame_age_rank[f];
    for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) begin
      if (i != f && frame_full[i] && frame_age_rank[i] > old_rank)
        frame_age_rank[i] = frame_age_rank[i] - 1'b1;
    end
    frame_age_rank[f] = lrupr_pkg::rank_t'(frames_in_use() - 1);
  endfunction

  function automatic access_result_t lookup_page(lrupr_pkg::page_t page);
    access_result_t r;
    int slot;
    int oldest;
    bit found;
    bit empty;
    r = '0;
    slot = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) begin
      if (!found && frame_full[i] && frame_page[i] == page) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      make_most_recent(slot);
    end else begin
      for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) begin
        if (!empty && !frame_full[i]) begin
          empty = 1'b1;
          slot = i;
        end
      end
      if (empty) begin
        frame_full[slot] = 1'b1;
        frame_page[slot] = page;
        frame_age_rank[slot] = lrupr_pkg::rank_t'(frames_in_use() - 1);
      end else begin
        oldest = 0;
        for (int i = 1; i < lrupr_pkg::FRAME_COUNT; i++)
          if (frame_age_rank[i] < frame_age_rank[oldest]) oldest = i;
        slot = oldest;
        r.ev_valid = 1'b1;
        r.ev_page = lrupr_pkg::IN_PAGE_W'(frame_page[slot]);
        frame_page[slot] = page;
        make_most_recent(slot);
      end
      if (fault_tally != '1) fault_tally = fault_tally + 1;
    end
    r.slot = lrupr_pkg::SLOT_W'(slot);
    r.faults = fault_tally;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    error_count++;
    $display("mismatch at %0t on result %0d: %s expected 0x%0h got 0x%0h",
             $realtime, results_seen, what, want, got);
  endtask

  // sender: sample at rising edge, drive at falling edge
  always @(posedge clk) begin
    page_taken = !rst && s_tvalid && s_tready;
    if (page_taken) begin
      expected_results.push_back(lookup_page(s_tdata[lrupr_pkg::PAGE_BITS-1:0]));
      void'(page_queue.pop_front());
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || page_taken) begin
      if (page_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= page_queue[0];
      end else begin
        s_tvalid <= 1'b0;
        s_tdata <= lrupr_pkg::IN_DATA_W'($urandom);
      end
    end
  end

  // receiver ready with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done = holds_asked;
      hold_left = 80;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = access_result_t'(m_tdata);
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result item", 0, m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (want.hit) hits_seen++;
        else if (want.ev_valid) evictions_seen++;
        else fills_seen++;
        if (got.hit !== want.hit) report_mismatch("hit", want.hit, got.hit);
        if (got.slot !== want.slot) report_mismatch("frame_slot", want.slot, got.slot);
        if (got.ev_valid !== want.ev_valid)
          report_mismatch("evicted_valid", want.ev_valid, got.ev_valid);
        if (got.ev_page !== want.ev_page)
          report_mismatch("evicted_page", want.ev_page, got.ev_page);
        if (got.faults !== want.faults)
          report_mismatch("fault_total", want.faults, got.faults);
      end
    end
  end

  task automatic wait_drained();
    while (page_queue.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  // runs over a shifting working set, with some pages carried over and some noise
  task automatic add_page_runs(int total);
    logic [lrupr_pkg::IN_DATA_W-1:0] pool [8];
    int pool_size;
    int run_len;
    int left;
    for (int j = 0; j < 8; j++) pool[j] = lrupr_pkg::IN_DATA_W'($urandom);
    left = total;
    while (left > 0) begin
      pool_size = $urandom_range(2, 8);
      for (int j = 0; j < 8; j++)
        if ($urandom_range(1)) pool[j] = lrupr_pkg::IN_DATA_W'($urandom);
      run_len = $urandom_range(12, 40);
      for (int k = 0; k < run_len && left > 0; k++) begin
        if ($urandom_range(99) < 10) page_queue.push_back(lrupr_pkg::IN_DATA_W'($urandom));
        else page_queue.push_back(pool[$urandom_range(pool_size - 1)]);
        left--;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < lrupr_pkg::FRAME_COUNT; i++) begin
      frame_page[i] = '0;
      frame_full[i] = 1'b0;
      frame_age_rank[i] = '0;
    end
    fault_tally = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    send_idle_pct = 25;
    recv_idle_pct = 86;
    // fill all frames, hits at bottom, middle and top rank, evictions, repeats
    page_queue = '{16'h0000, 16'hffff, 16'h5555, 16'haaaa, 16'h0000, 16'haaaa,
                   16'h5555, 16'h1234, 16'h8001, 16'h1234, 16'hffff, 16'h0001,
                   16'h8000, 16'h7fff, 16'h7fff, 16'h0000, 16'hffff, 16'h8000,
                   16'h0001, 16'h7fff};
    add_page_runs(220);
    wait_drained();

    send_idle_pct = 86;
    recv_idle_pct = 25;
    add_page_runs(230);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_page_runs(230);
    holds_asked++;
    wait_drained();

    repeat (10) @(posedge clk);
    $display("covered %0d accesses: %0d hits, %0d fills of empty frames, %0d evictions",
             results_seen, hits_seen, fills_seen, evictions_seen);
    $display("final fault count %0d, long receiver hold-off and sender drain pauses done",
             fault_tally);
    if (error_count == 0) begin
      $display("lru_page_replacement_core_test: clean");
    end else begin
      $display("lru_page_replacement_core_test: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", expected_results.size());
    $display("lru_page_replacement_core_test: errors");
    $finish;
  end

endmodule
